// ===== src/mi3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// shared types and constants for the 3x3 matrix inverse pipeline
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int unsigned DataW       = 32;
  localparam int unsigned CofW        = 64;
  localparam int unsigned TermW       = 97;
  localparam int unsigned MinW        = 31;
  localparam int unsigned DefFracBits = 16;
  localparam int unsigned NumCof      = 9;
  localparam int unsigned DivStages   = 32;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a02;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [31:0] a12;
    logic signed [31:0] a20;
    logic signed [31:0] a21;
    logic signed [31:0] a22;
    logic signed [31:0] given_determinant;
  } in_t;

  typedef struct packed {
    logic signed [31:0] inv00;
    logic signed [31:0] inv01;
    logic signed [31:0] inv02;
    logic signed [31:0] inv10;
    logic signed [31:0] inv11;
    logic signed [31:0] inv12;
    logic signed [31:0] inv20;
    logic signed [31:0] inv21;
    logic signed [31:0] inv22;
    logic signed [31:0] det_used;
    logic               singular;
  } out_t;

  // column-0 elements and caller determinant carried alongside the cofactors
  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a10;
    logic signed [31:0] a20;
    logic signed [31:0] given;
  } col_t;

endpackage

// ===== src/mi3_cof.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof
// two-stage cofactor unit: 18 products, then nine 2x2 differences
// ----------------------------------------------------------------------------
module mi3_cof (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  mi3_pkg::in_t                  in_i,
  output logic signed [mi3_pkg::CofW-1:0] cof_o [mi3_pkg::NumCof],
  output mi3_pkg::col_t                 col_o
);

  logic signed [63:0] p_q [18];
  logic signed [63:0] p_d [18];
  mi3_pkg::col_t      col1_q;
  logic signed [63:0] cof_q [mi3_pkg::NumCof];
  mi3_pkg::col_t      col2_q;

  always_comb begin
    p_d[0]  = in_i.a22 * in_i.a11;  p_d[1]  = in_i.a21 * in_i.a12;
    p_d[2]  = in_i.a21 * in_i.a02;  p_d[3]  = in_i.a22 * in_i.a01;
    p_d[4]  = in_i.a12 * in_i.a01;  p_d[5]  = in_i.a11 * in_i.a02;
    p_d[6]  = in_i.a20 * in_i.a12;  p_d[7]  = in_i.a22 * in_i.a10;
    p_d[8]  = in_i.a22 * in_i.a00;  p_d[9]  = in_i.a20 * in_i.a02;
    p_d[10] = in_i.a10 * in_i.a02;  p_d[11] = in_i.a12 * in_i.a00;
    p_d[12] = in_i.a21 * in_i.a10;  p_d[13] = in_i.a20 * in_i.a11;
    p_d[14] = in_i.a20 * in_i.a01;  p_d[15] = in_i.a21 * in_i.a00;
    p_d[16] = in_i.a11 * in_i.a00;  p_d[17] = in_i.a10 * in_i.a01;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 18; i++) begin
        p_q[i] <= p_d[i];
      end
      col1_q <= '{a00: in_i.a00, a10: in_i.a10, a20: in_i.a20,
                  given: in_i.given_determinant};
      // differences wrap at 64 bits
      for (int k = 0; k < 9; k++) begin
        cof_q[k] <= p_q[2*k] - p_q[2*k+1];
      end
      col2_q <= col1_q;
    end
  end

  assign cof_o = cof_q;
  assign col_o = col2_q;

endmodule

// ===== src/mi3_det.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// three-stage determinant: split products, term assembly, sum/shift/saturate
// ----------------------------------------------------------------------------
module mi3_det #(
  parameter int unsigned FRAC_BITS = mi3_pkg::DefFracBits
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [mi3_pkg::CofW-1:0] cof0_i,
  input  logic signed [mi3_pkg::CofW-1:0] cof1_i,
  input  logic signed [mi3_pkg::CofW-1:0] cof2_i,
  input  mi3_pkg::col_t                  col_i,
  output logic signed [31:0]             det_o
);

  localparam int unsigned Shift = 2 * FRAC_BITS;

  logic signed [31:0] a   [3];
  logic signed [63:0] c   [3];
  logic signed [64:0] pl_q [3];
  logic signed [63:0] ph_q [3];
  logic signed [31:0] given3_q, given4_q;
  logic signed [mi3_pkg::TermW-1:0] t_q [3];
  logic signed [mi3_pkg::TermW-1:0] sum, sh;
  logic                fits;
  logic signed [31:0]  sat;
  logic signed [31:0]  det_q;

  assign a[0] = col_i.a00;  assign c[0] = cof0_i;
  assign a[1] = col_i.a10;  assign c[1] = cof1_i;
  assign a[2] = col_i.a20;  assign c[2] = cof2_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        // low half unsigned, high half signed
        pl_q[i] <= a[i] * $signed({1'b0, c[i][31:0]});
        ph_q[i] <= a[i] * $signed(c[i][63:32]);
        t_q[i]  <= $signed({ph_q[i][63], ph_q[i], 32'h0})
                 + $signed({{32{pl_q[i][64]}}, pl_q[i]});
      end
      given3_q <= col_i.given;
      given4_q <= given3_q;
      det_q    <= (given4_q != 32'sd0) ? given4_q : sat;
    end
  end

  always_comb begin
    sum  = t_q[0] + t_q[1] + t_q[2];
    sh   = sum >>> Shift;
    fits = (&sh[mi3_pkg::TermW-1:31]) | ~(|sh[mi3_pkg::TermW-1:31]);
    sat  = fits ? sh[31:0] : (sh[mi3_pkg::TermW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
  end

  assign det_o = det_q;

endmodule

// ===== src/mi3_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div
// pipelined restoring divider lane, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
module mi3_div (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [mi3_pkg::CofW-1:0] cof_i,
  input  logic signed [31:0]             det_i,
  output logic signed [31:0]             quo_o
);

  localparam int unsigned N = mi3_pkg::DivStages;

  logic [63:0] mc;
  logic [31:0] md;
  logic [31:0] rem_q [N+1];
  logic [31:0] lo_q  [N+1];
  logic [31:0] quo_q [N+1];
  logic [31:0] d_q   [N+1];
  logic        neg_q [N+1];
  logic        ovf_q [N+1];
  logic [32:0] r     [N];
  logic        ge    [N];
  logic [31:0] qf;

  assign mc = cof_i[63] ? 64'(-cof_i) : 64'(cof_i);
  assign md = det_i[31] ? 32'(-det_i) : 32'(det_i);

  always_comb begin
    for (int k = 0; k < N; k++) begin
      r[k]  = {rem_q[k], lo_q[k][31]};
      ge[k] = r[k] >= {1'b0, d_q[k]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= mc[63:32];
      lo_q[0]  <= mc[31:0];
      quo_q[0] <= '0;
      d_q[0]   <= md;
      neg_q[0] <= cof_i[63] ^ det_i[31];
      // quotient of 2^32 or more, also covers a zero divisor
      ovf_q[0] <= mc[63:32] >= md;
      for (int k = 0; k < N; k++) begin
        rem_q[k+1] <= ge[k] ? 32'(r[k] - {1'b0, d_q[k]}) : r[k][31:0];
        lo_q[k+1]  <= {lo_q[k][30:0], 1'b0};
        quo_q[k+1] <= {quo_q[k][30:0], ge[k]};
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  always_comb begin
    qf = quo_q[N];
    if (neg_q[N]) begin
      quo_o = (ovf_q[N] || qf > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-qf);
    end else begin
      quo_o = (ovf_q[N] || qf > 32'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(qf);
    end
  end

endmodule

// ===== src/matrix3x3_inverse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3x3_inverse
// pipelined 3x3 Q16.16 matrix inverse by the adjugate
// ----------------------------------------------------------------------------
// Accepts one matrix per clock while the output is not stalled. Each of the
// nine cofactors is divided by the determinant in its own restoring divider,
// one quotient bit per stage over 32 stages. Before that, two stages form
// the cofactors and three form the determinant (caller's value used when
// nonzero). Quotients truncate toward zero and saturate to 32 bits; a
// determinant whose magnitude is at or below min_abs_determinant flags
// singular and zeroes the inverse. A stalled output holds the whole
// pipeline; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = mi3_pkg::DefFracBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [mi3_pkg::MinW-1:0]    cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  mi3_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mi3_pkg::out_t               out_data_o
);

  // register stages: cofactor 2, determinant 3, divider 33, output 1
  localparam int unsigned CofLat = 2;
  localparam int unsigned DetLat = 3;
  localparam int unsigned DivLat = mi3_pkg::DivStages + 1;
  localparam int unsigned Depth  = CofLat + DetLat + DivLat + 1;

  logic [Depth-1:0]             vld_q;
  logic                         adv;
  logic [mi3_pkg::MinW-1:0]     min_abs_q;

  logic signed [63:0]           cof  [mi3_pkg::NumCof];
  mi3_pkg::col_t                col;
  logic signed [63:0]           cof_dly_q [DetLat][mi3_pkg::NumCof];
  logic signed [31:0]           det;
  logic [31:0]                  det_mag;
  logic                         sing;
  logic signed [31:0]           det_line_q  [DivLat];
  logic                         sing_line_q [DivLat];
  logic signed [31:0]           quo [mi3_pkg::NumCof];
  mi3_pkg::out_t                out_q;

  // whole pipeline moves unless a finished result is waiting and out_ready_i is low
  assign adv        = ~vld_q[Depth-1] | out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      min_abs_q <= '0;
    end else begin
      if (adv) begin
        vld_q <= {vld_q[Depth-2:0], in_valid_i};
      end
      if (cfg_we_i) begin
        min_abs_q <= cfg_wdata_i;
      end
    end
  end

  mi3_cof u_cof (
    .clk_i (clk_i),
    .en_i  (adv),
    .in_i  (in_data_i),
    .cof_o (cof),
    .col_o (col)
  );

  mi3_det #(
    .FRAC_BITS (FRAC_BITS)
  ) u_det (
    .clk_i  (clk_i),
    .en_i   (adv),
    .cof0_i (cof[0]),
    .cof1_i (cof[1]),
    .cof2_i (cof[2]),
    .col_i  (col),
    .det_o  (det)
  );

  // cofactors wait for the determinant
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cof_dly_q[0] <= cof;
      for (int s = 1; s < DetLat; s++) begin
        cof_dly_q[s] <= cof_dly_q[s-1];
      end
    end
  end

  // singular test against the register
  assign det_mag = det[31] ? 32'(-det) : 32'(det);
  assign sing    = det_mag <= {1'b0, min_abs_q};

  // determinant and flag ride alongside the divider lanes
  always_ff @(posedge clk_i) begin
    if (adv) begin
      det_line_q[0]  <= det;
      sing_line_q[0] <= sing;
      for (int s = 1; s < DivLat; s++) begin
        det_line_q[s]  <= det_line_q[s-1];
        sing_line_q[s] <= sing_line_q[s-1];
      end
    end
  end

  for (genvar g = 0; g < mi3_pkg::NumCof; g++) begin : g_lane
    mi3_div u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .cof_i (cof_dly_q[DetLat-1][g]),
      .det_i (det),
      .quo_o (quo[g])
    );
  end

  // output register, zeroed inverse on a singular matrix
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.inv00    <= sing_line_q[DivLat-1] ? '0 : quo[0];
      out_q.inv01    <= sing_line_q[DivLat-1] ? '0 : quo[1];
      out_q.inv02    <= sing_line_q[DivLat-1] ? '0 : quo[2];
      out_q.inv10    <= sing_line_q[DivLat-1] ? '0 : quo[3];
      out_q.inv11    <= sing_line_q[DivLat-1] ? '0 : quo[4];
      out_q.inv12    <= sing_line_q[DivLat-1] ? '0 : quo[5];
      out_q.inv20    <= sing_line_q[DivLat-1] ? '0 : quo[6];
      out_q.inv21    <= sing_line_q[DivLat-1] ? '0 : quo[7];
      out_q.inv22    <= sing_line_q[DivLat-1] ? '0 : quo[8];
      out_q.det_used <= det_line_q[DivLat-1];
      out_q.singular <= sing_line_q[DivLat-1];
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;

endmodule
